@@ rtl/core/owm_pkg.sv @@
// Shared types and constants for the one-wire bus master.
// No dependencies; compiled first.
package owm_pkg;

   // command codes carried on the request channel
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_RESET = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // sequencer phase codes
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_TAIL = 4'd3;
   localparam logic [3:0] PH_WR_SLOT  = 4'd4;
   localparam logic [3:0] PH_WR_REC   = 4'd5;
   localparam logic [3:0] PH_RD_SLOT  = 4'd6;
   localparam logic [3:0] PH_RD_REC   = 4'd7;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_LOW_TIME = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENCE_WAIT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_TAIL     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_TIME      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WRITE_ONE_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_LOW       = 3'd5;

   // register reset values (bus timing in microseconds)
   localparam logic [9:0] RESET_LOW_TIME_DEF = 10'd480;
   localparam logic [9:0] PRESENCE_WAIT_DEF  = 10'd80;
   localparam logic [9:0] RESET_TAIL_DEF     = 10'd400;
   localparam logic [7:0] SLOT_TIME_DEF      = 8'd60;
   localparam logic [7:0] WRITE_ONE_LOW_DEF  = 8'd1;
   localparam logic [7:0] READ_LOW_DEF       = 8'd2;

   // per-tick flags from the sequencer
   typedef struct packed {
      logic drive_low;
      logic busy;
      logic done;
   } owm_flags_type;

endpackage

@@ rtl/core/owm_if.sv @@
// Valid/ready channel interfaces for the one-wire bus master.
// No package dependency.
interface owm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] write_byte;
   logic       line_level;

   modport source (output valid, command, write_byte, line_level, input ready);
   modport sink   (input valid, command, write_byte, line_level, output ready);
endinterface

interface owm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic       reset_ok;
   logic [7:0] read_byte;

   modport source (output valid, drive_low, busy_res, done_res, reset_ok, read_byte,
                   input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, reset_ok, read_byte,
                   output ready);
endinterface

@@ rtl/core/owm_step.sv @@
// One-tick next-state logic of the bus sequencer (pure combinational).
// Depends on owm_pkg.
module owm_step #(
   parameter int unsigned TIMER_WIDTH = 10
) (
   input  logic [9:0]             reset_low_time,
   input  logic [9:0]             presence_wait,
   input  logic [9:0]             reset_tail,
   input  logic [7:0]             slot_time,
   input  logic [7:0]             write_one_low,
   input  logic [7:0]             read_low,
   input  logic [1:0]             command,
   input  logic [7:0]             write_byte,
   input  logic                   line_level,
   input  logic [3:0]             phase,
   input  logic [TIMER_WIDTH-1:0] timer,
   input  logic [2:0]             bit_index,
   input  logic [7:0]             shift_byte,
   input  logic                   presence,
   input  logic [7:0]             read_data,
   output logic [3:0]             phase_nx,
   output logic [TIMER_WIDTH-1:0] timer_nx,
   output logic [2:0]             bit_index_nx,
   output logic [7:0]             shift_byte_nx,
   output logic                   presence_nx,
   output logic [7:0]             read_data_nx,
   output owm_pkg::owm_flags_type flags
);
   localparam int unsigned CW = TIMER_WIDTH + 1;
   localparam int unsigned LW = (CW > 11) ? CW : 11;

   logic [3:0]             ph_e;
   logic [TIMER_WIDTH-1:0] timer_e;
   logic [2:0]             bit_e;
   logic [7:0]             shift_e;
   logic                   pres_e;
   logic [CW-1:0]          cnt_plus;
   logic [LW-1:0]          cnt_ext;
   logic [LW-1:0]          timer_ext;
   logic [7:0]             st1, wol1, rl1, wr_low, wr_len;
   logic [8:0]             rd_len, rl1_p1;
   logic [9:0]             rt1;
   logic [LW-1:0]          len_sel;
   logic                   ends;

   // zero-valued timing registers act as one
   assign st1  = (slot_time == 8'd0) ? 8'd1 : slot_time;
   assign wol1 = (write_one_low == 8'd0) ? 8'd1 : write_one_low;
   assign rl1  = (read_low == 8'd0) ? 8'd1 : read_low;
   assign rt1  = (reset_tail == 10'd0) ? 10'd1 : reset_tail;
   assign rl1_p1 = {1'b0, rl1} + 9'd1;

   // effective state after a possible command start
   always_comb begin
      ph_e    = (phase > owm_pkg::PH_RD_REC) ? owm_pkg::PH_IDLE : phase;
      timer_e = timer;
      bit_e   = bit_index;
      shift_e = shift_byte;
      pres_e  = presence;
      if (ph_e == owm_pkg::PH_IDLE && command != owm_pkg::CMD_NONE) begin
         timer_e = '0;
         bit_e   = 3'd0;
         case (command)
            owm_pkg::CMD_RESET: begin
               ph_e   = owm_pkg::PH_RST_LOW;
               pres_e = 1'b0;
            end
            owm_pkg::CMD_WRITE: begin
               ph_e    = owm_pkg::PH_WR_SLOT;
               shift_e = write_byte;
            end
            default: begin
               ph_e    = owm_pkg::PH_RD_SLOT;
               shift_e = 8'd0;
            end
         endcase
      end
   end

   assign cnt_plus  = {1'b0, timer_e} + CW'(1);
   assign cnt_ext   = LW'(cnt_plus);
   assign timer_ext = LW'(timer_e);
   assign wr_low    = shift_e[bit_e] ? wol1 : st1;
   assign wr_len    = (st1 > wr_low) ? st1 : wr_low;
   assign rd_len    = ({1'b0, st1} > rl1_p1) ? {1'b0, st1} : rl1_p1;

   // length of the running phase
   always_comb begin
      case (ph_e)
         owm_pkg::PH_RST_LOW:  len_sel = LW'(reset_low_time);
         owm_pkg::PH_RST_WAIT: len_sel = LW'(presence_wait);
         owm_pkg::PH_RST_TAIL: len_sel = LW'({1'b0, rt1} + 11'd1);
         owm_pkg::PH_WR_SLOT:  len_sel = LW'(wr_len);
         owm_pkg::PH_RD_SLOT:  len_sel = LW'(rd_len);
         default:              len_sel = LW'(1);
      endcase
   end

   // last tick: counter reached the length, or the timer is at its top
   assign ends = (cnt_ext >= ((len_sel == '0) ? LW'(1) : len_sel)) || cnt_plus[CW-1];

   always_comb begin
      phase_nx      = ph_e;
      timer_nx      = ends ? '0 : cnt_plus[TIMER_WIDTH-1:0];
      bit_index_nx  = bit_e;
      shift_byte_nx = shift_e;
      presence_nx   = pres_e;
      read_data_nx  = read_data;
      flags         = '{drive_low: 1'b0, busy: 1'b1, done: 1'b0};
      case (ph_e)
         owm_pkg::PH_RST_LOW: begin
            flags.drive_low = 1'b1;
            if (ends) phase_nx = owm_pkg::PH_RST_WAIT;
         end
         owm_pkg::PH_RST_WAIT: begin
            if (ends) phase_nx = owm_pkg::PH_RST_TAIL;
         end
         owm_pkg::PH_RST_TAIL: begin
            if (timer_e == '0) presence_nx = ~line_level;
            if (ends) begin
               presence_nx = presence_nx & line_level;
               flags.done  = 1'b1;
               phase_nx    = owm_pkg::PH_IDLE;
            end
         end
         owm_pkg::PH_WR_SLOT: begin
            flags.drive_low = timer_ext < LW'(wr_low);
            if (ends) phase_nx = owm_pkg::PH_WR_REC;
         end
         owm_pkg::PH_RD_SLOT: begin
            flags.drive_low = timer_ext < LW'(rl1);
            if (timer_ext == LW'(rl1)) shift_byte_nx = {line_level, shift_e[7:1]};
            if (ends) phase_nx = owm_pkg::PH_RD_REC;
         end
         owm_pkg::PH_WR_REC, owm_pkg::PH_RD_REC: begin
            timer_nx = '0;
            if (bit_e == 3'd7) begin
               if (ph_e == owm_pkg::PH_RD_REC) read_data_nx = shift_e;
               flags.done   = 1'b1;
               bit_index_nx = 3'd0;
               phase_nx     = owm_pkg::PH_IDLE;
            end else begin
               bit_index_nx = bit_e + 3'd1;
               phase_nx     = (ph_e == owm_pkg::PH_RD_REC) ? owm_pkg::PH_RD_SLOT
                                                           : owm_pkg::PH_WR_SLOT;
            end
         end
         default: begin
            flags.busy = 1'b0;
         end
      endcase
   end

endmodule

@@ rtl/core/one_wire_bus_master.sv @@
// Top level of the one-wire bus master: channel registers, timing registers
// and sequencer state. Depends on owm_pkg, owm_if.sv and owm_step.
//
//  channel    dir   beat                                     width
//  req_chan   in    command, write_byte, line_level           2+8+1
//  rsp_chan   out   drive_low, busy_res, done_res,            1+1+1+1+8
//                   reset_ok, read_byte
//  csr_*      in    wr_en, index (0..5), wdata                1+3+10
//
// Every request beat is one bus tick and yields exactly one response beat.
// Beats pass the input register, then the result register; one beat per cycle
// is sustained while responses are taken (single-tick sequencer update).
// Reset (synchronous, active high) returns the sequencer to idle and the
// timing registers to their defaults; no clearing pass.
// A stalled response holds its register; the input register takes beats while
// it is empty or while the response register is free or being taken.
module one_wire_bus_master #(
   parameter int unsigned TIMER_WIDTH = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   owm_req_if.sink                               req_chan,
   owm_rsp_if.source                             rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [owm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [owm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // timing registers
   logic [9:0] reset_low_time_ff, presence_wait_ff, reset_tail_ff;
   logic [7:0] slot_time_ff, write_one_low_ff, read_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_time_ff <= owm_pkg::RESET_LOW_TIME_DEF;
         presence_wait_ff  <= owm_pkg::PRESENCE_WAIT_DEF;
         reset_tail_ff     <= owm_pkg::RESET_TAIL_DEF;
         slot_time_ff      <= owm_pkg::SLOT_TIME_DEF;
         write_one_low_ff  <= owm_pkg::WRITE_ONE_LOW_DEF;
         read_low_ff       <= owm_pkg::READ_LOW_DEF;
      end else if (csr_wr_en) begin
         case (csr_index)
            owm_pkg::CSR_RESET_LOW_TIME: reset_low_time_ff <= csr_wdata[9:0];
            owm_pkg::CSR_PRESENCE_WAIT:  presence_wait_ff  <= csr_wdata[9:0];
            owm_pkg::CSR_RESET_TAIL:     reset_tail_ff     <= csr_wdata[9:0];
            owm_pkg::CSR_SLOT_TIME:      slot_time_ff      <= csr_wdata[7:0];
            owm_pkg::CSR_WRITE_ONE_LOW:  write_one_low_ff  <= csr_wdata[7:0];
            owm_pkg::CSR_READ_LOW:       read_low_ff       <= csr_wdata[7:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [1:0] cmd_ff;
   logic [7:0] wb_ff;
   logic       lvl_ff;
   logic       out_vld_ff, out_vld_in;
   logic       advance;   // tick in the input register is processed this cycle
   logic       req_take;

   assign advance         = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready  = !in_vld_ff || advance;
   assign req_take        = req_chan.valid && req_chan.ready;
   assign in_vld_in       = req_take ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in      = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= req_chan.command;
         wb_ff  <= req_chan.write_byte;
         lvl_ff <= req_chan.line_level;
      end
   end

   // sequencer state
   logic [3:0]             phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic [7:0]             shift_byte_ff, shift_byte_in;
   logic                   presence_ff, presence_in;
   logic [7:0]             read_data_ff, read_data_in;
   owm_pkg::owm_flags_type flags;

   owm_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step (
      .reset_low_time (reset_low_time_ff),
      .presence_wait  (presence_wait_ff),
      .reset_tail     (reset_tail_ff),
      .slot_time      (slot_time_ff),
      .write_one_low  (write_one_low_ff),
      .read_low       (read_low_ff),
      .command        (cmd_ff),
      .write_byte     (wb_ff),
      .line_level     (lvl_ff),
      .phase          (phase_ff),
      .timer          (timer_ff),
      .bit_index      (bit_index_ff),
      .shift_byte     (shift_byte_ff),
      .presence       (presence_ff),
      .read_data      (read_data_ff),
      .phase_nx       (phase_in),
      .timer_nx       (timer_in),
      .bit_index_nx   (bit_index_in),
      .shift_byte_nx  (shift_byte_in),
      .presence_nx    (presence_in),
      .read_data_nx   (read_data_in),
      .flags          (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= owm_pkg::PH_IDLE;
         timer_ff      <= '0;
         bit_index_ff  <= 3'd0;
         shift_byte_ff <= 8'd0;
         presence_ff   <= 1'b0;
         read_data_ff  <= 8'd0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         timer_ff      <= timer_in;
         bit_index_ff  <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         presence_ff   <= presence_in;
         read_data_ff  <= read_data_in;
      end
   end

   // result register
   owm_pkg::owm_flags_type flags_ff;
   logic                   reset_ok_ff;
   logic [7:0]             read_byte_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         flags_ff     <= flags;
         reset_ok_ff  <= presence_in;
         read_byte_ff <= read_data_in;
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.drive_low = flags_ff.drive_low;
   assign rsp_chan.busy_res  = flags_ff.busy;
   assign rsp_chan.done_res  = flags_ff.done;
   assign rsp_chan.reset_ok  = reset_ok_ff;
   assign rsp_chan.read_byte = read_byte_ff;

   // checks
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> rsp_chan.busy_res)
      else $error("done without busy");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.drive_low |-> rsp_chan.busy_res)
      else $error("bus driven while idle");

   a_tick_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("processed tick produced no response");

   a_bit_phase: assert property (@(posedge clock) disable iff (reset)
      bit_index_ff != 3'd0 |-> (phase_ff == owm_pkg::PH_WR_SLOT ||
         phase_ff == owm_pkg::PH_WR_REC || phase_ff == owm_pkg::PH_RD_SLOT ||
         phase_ff == owm_pkg::PH_RD_REC))
      else $error("bit index set outside a byte transfer");

endmodule
